// ===== hw/rtl/chrd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package chrd_pkg;

  localparam int INDEX_WIDTH = 16;
  localparam int COUNT_WIDTH = 32;
  localparam int SEED_WIDTH  = 32;
  localparam int HASH_WIDTH  = 64;
  localparam int HALF_WIDTH  = HASH_WIDTH / 2;
  localparam int REJ_WIDTH   = 8;

  localparam logic [HASH_WIDTH-1:0] GOLDEN_STEP     = 64'h9e3779b97f4a7c15;
  localparam logic [HASH_WIDTH-1:0] MUL_FIRST       = 64'hbf58476d1ce4e5b9;
  localparam logic [HASH_WIDTH-1:0] MUL_SECOND      = 64'h94d049bb133111eb;
  localparam logic [HASH_WIDTH-1:0] SIGN_STREAM     = 64'h5f4d3c2b1a098765;
  localparam logic [HASH_WIDTH-1:0] SCHEDULE_STREAM = 64'h84a19c37d52e6bf0;

  localparam int SHIFT_FIRST  = 30;
  localparam int SHIFT_SECOND = 27;
  localparam int SHIFT_FINAL  = 31;

  localparam logic FUNC_SIGN  = 1'b0;
  localparam logic FUNC_INDEX = 1'b1;

  typedef struct packed {
    logic                   func;
    logic [COUNT_WIDTH-1:0] update_count;
    logic [INDEX_WIDTH-1:0] block_num;
    logic [INDEX_WIDTH-1:0] replication_index;
    logic [INDEX_WIDTH-1:0] coordinate_index;
    logic [INDEX_WIDTH-1:0] bound;
  } in_req_t;

  typedef struct packed {
    logic [HASH_WIDTH-1:0]  raw_value;
    logic                   sign_positive;
    logic [INDEX_WIDTH-1:0] index;
    logic [REJ_WIDTH-1:0]   rejections;
    logic                   bad_bound;
  } out_res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/chrd_mul64.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Low 64 bits of a 64 x 64 product, built from three 32 x 32 partial
// products on one multiplier. The high-by-high term never reaches the low word.
module chrd_mul64 (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  input  wire logic [chrd_pkg::HASH_WIDTH-1:0] op_a,
  input  wire logic [chrd_pkg::HASH_WIDTH-1:0] op_b,
  output logic                                done,
  output logic [chrd_pkg::HASH_WIDTH-1:0]     product
);

  localparam int HW = chrd_pkg::HALF_WIDTH;
  localparam int FW = chrd_pkg::HASH_WIDTH;

  logic [FW-1:0] a_r, b_r, acc_r, prod_r, prod_nxt;
  logic [1:0]    step_r;
  logic          busy_r, done_r;
  logic [HW-1:0] mul_x, mul_y;

  always_comb begin
    case (step_r)
      2'd1: begin
        mul_x = a_r[HW-1:0];
        mul_y = b_r[FW-1:HW];
      end
      2'd2: begin
        mul_x = a_r[FW-1:HW];
        mul_y = b_r[HW-1:0];
      end
      default: begin
        mul_x = a_r[HW-1:0];
        mul_y = b_r[HW-1:0];
      end
    endcase
    prod_nxt = {{HW{1'b0}}, mul_x} * {{HW{1'b0}}, mul_y};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= 2'd0;
    end else begin
      done_r <= 1'b0;
      if (!busy_r) begin
        if (start) begin
          busy_r <= 1'b1;
          step_r <= 2'd0;
        end
      end else begin
        step_r <= step_r + 2'd1;
        if (step_r == 2'd3) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!busy_r && start) begin
      a_r <= op_a;
      b_r <= op_b;
    end
    if (busy_r) begin
      prod_r <= prod_nxt;
      case (step_r)
        2'd1:    acc_r <= prod_r;
        2'd2:    acc_r[FW-1:HW] <= acc_r[FW-1:HW] + prod_r[HW-1:0];
        2'd3:    acc_r[FW-1:HW] <= acc_r[FW-1:HW] + prod_r[HW-1:0];
        default: acc_r <= acc_r;
      endcase
    end
  end

  assign done    = done_r;
  assign product = acc_r;

endmodule

`default_nettype wire

// ===== hw/rtl/chrd_mod.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Restoring remainder, one dividend bit per cycle, most significant first.
module chrd_mod (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  input  wire logic [chrd_pkg::HASH_WIDTH-1:0]  dividend,
  input  wire logic [chrd_pkg::INDEX_WIDTH-1:0] divisor,
  output logic                                 done,
  output logic [chrd_pkg::INDEX_WIDTH-1:0]     remainder
);

  localparam int DW = chrd_pkg::HASH_WIDTH;
  localparam int RW = chrd_pkg::INDEX_WIDTH;
  localparam int CW = $clog2(DW);
  localparam logic [CW-1:0] LAST_STEP = CW'(DW - 1);

  logic [DW-1:0] dvd_r;
  logic [RW-1:0] dvs_r, rem_r, rem_nxt;
  logic [CW-1:0] cnt_r;
  logic          busy_r, done_r;
  logic [RW:0]   trial;

  always_comb begin
    trial = {rem_r, dvd_r[DW-1]};
    // The partial remainder stays below the divisor, so the difference fits.
    if (trial >= {1'b0, dvs_r}) begin
      rem_nxt = RW'(trial - {1'b0, dvs_r});
    end else begin
      rem_nxt = trial[RW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (!busy_r) begin
        if (start) begin
          busy_r <= 1'b1;
          cnt_r  <= '0;
        end
      end else begin
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!busy_r && start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DW-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

// ===== hw/rtl/counter_hash_random_draw.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Counter-based random draw on the splitmix64 finalizer, one request at a
// time. The input is stalled from acceptance until the result has been moved
// to the output register, which can hold one finished result while the next
// request is accepted. Each of the six finalizer rounds takes one add step
// and two 64-bit products on a single shared 32 x 32 multiplier. An index
// draw also runs the one-bit-per-cycle remainder unit twice, once for the
// rejection threshold and once for the final index, and each rejected
// attempt reruns all six rounds. An index draw with bound zero returns
// without hashing, with bad_bound set.
module counter_hash_random_draw (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire chrd_pkg::in_req_t                   in_req,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output chrd_pkg::out_res_t                       out_res,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [chrd_pkg::SEED_WIDTH-1:0]     cfg_data
);

  localparam int HW = chrd_pkg::HASH_WIDTH;
  localparam int IW = chrd_pkg::INDEX_WIDTH;
  localparam int RW = chrd_pkg::REJ_WIDTH;

  localparam logic [2:0] ROUND_SEED   = 3'd0;
  localparam logic [2:0] ROUND_STREAM = 3'd1;
  localparam logic [2:0] ROUND_UPDATE = 3'd2;
  localparam logic [2:0] ROUND_BLOCK  = 3'd3;
  localparam logic [2:0] ROUND_REPL   = 3'd4;
  localparam logic [2:0] ROUND_COORD  = 3'd5;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_THR   = 8'b0000_0010,
    S_ADD   = 8'b0000_0100,
    S_MUL1  = 8'b0000_1000,
    S_MUL2  = 8'b0001_0000,
    S_CHECK = 8'b0010_0000,
    S_MOD   = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t              state_r, state_nxt;
  chrd_pkg::in_req_t   req_r, req_nxt;
  chrd_pkg::out_res_t  res_r, res_nxt;
  logic [chrd_pkg::SEED_WIDTH-1:0] seed_r;
  logic [HW-1:0]       x_r, x_nxt, h_r, h_nxt, attempt_r, attempt_nxt;
  logic [IW-1:0]       thr_r, thr_nxt, idx_r, idx_nxt;
  logic [2:0]          round_r, round_nxt, round_up;
  logic                bad_r, bad_nxt, out_valid_r, out_load;

  logic                mul_start, mul_done;
  logic [HW-1:0]       mul_a, mul_b, mul_p, sum, fin, word;
  logic                div_start, div_done;
  logic [HW-1:0]       div_dvd;
  logic [IW-1:0]       div_dvs, div_rem;
  logic [HW-1:0]       seed_ext;

  chrd_mul64 u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .op_a    (mul_a),
    .op_b    (mul_b),
    .done    (mul_done),
    .product (mul_p)
  );

  chrd_mod u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dvd),
    .divisor   (div_dvs),
    .done      (div_done),
    .remainder (div_rem)
  );

  assign seed_ext = {{(HW - chrd_pkg::SEED_WIDTH){1'b0}}, seed_r};
  assign sum      = x_r + chrd_pkg::GOLDEN_STEP;
  assign fin      = mul_p ^ (mul_p >> chrd_pkg::SHIFT_FINAL);
  assign round_up = round_r + 3'd1;

  // Word mixed into the hash ahead of the next round.
  always_comb begin
    case (round_up)
      ROUND_STREAM: word = (req_r.func == chrd_pkg::FUNC_INDEX) ?
                           chrd_pkg::SCHEDULE_STREAM : chrd_pkg::SIGN_STREAM;
      ROUND_UPDATE: word = {{(HW - chrd_pkg::COUNT_WIDTH){1'b0}}, req_r.update_count};
      ROUND_BLOCK:  word = {{(HW - IW){1'b0}}, req_r.block_num};
      ROUND_REPL:   word = (req_r.func == chrd_pkg::FUNC_INDEX) ? attempt_r :
                           {{(HW - IW){1'b0}}, req_r.replication_index};
      ROUND_COORD:  word = (req_r.func == chrd_pkg::FUNC_INDEX) ? '0 :
                           {{(HW - IW){1'b0}}, req_r.coordinate_index};
      default:      word = '0;
    endcase
  end

  always_comb begin
    state_nxt   = state_r;
    req_nxt     = req_r;
    x_nxt       = x_r;
    h_nxt       = h_r;
    attempt_nxt = attempt_r;
    thr_nxt     = thr_r;
    idx_nxt     = idx_r;
    round_nxt   = round_r;
    bad_nxt     = bad_r;
    res_nxt     = res_r;
    out_load    = 1'b0;
    mul_start   = 1'b0;
    mul_a       = sum ^ (sum >> chrd_pkg::SHIFT_FIRST);
    mul_b       = chrd_pkg::MUL_FIRST;
    div_start   = 1'b0;
    div_dvd     = h_r;
    div_dvs     = req_r.bound;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt     = in_req;
          x_nxt       = seed_ext;
          h_nxt       = '0;
          attempt_nxt = '0;
          idx_nxt     = '0;
          round_nxt   = ROUND_SEED;
          bad_nxt     = 1'b0;
          if (in_req.func == chrd_pkg::FUNC_SIGN) begin
            state_nxt = S_ADD;
          end else if (in_req.bound == '0) begin
            bad_nxt   = 1'b1;
            state_nxt = S_DONE;
          end else begin
            // (2^64 - bound) mod bound is the remainder of -bound in 64 bits.
            div_start = 1'b1;
            div_dvd   = '0 - {{(HW - IW){1'b0}}, in_req.bound};
            div_dvs   = in_req.bound;
            state_nxt = S_THR;
          end
        end
      end
      S_THR: begin
        if (div_done) begin
          thr_nxt   = div_rem;
          state_nxt = S_ADD;
        end
      end
      S_ADD: begin
        mul_start = 1'b1;
        state_nxt = S_MUL1;
      end
      S_MUL1: begin
        mul_a = mul_p ^ (mul_p >> chrd_pkg::SHIFT_SECOND);
        mul_b = chrd_pkg::MUL_SECOND;
        if (mul_done) begin
          mul_start = 1'b1;
          state_nxt = S_MUL2;
        end
      end
      S_MUL2: begin
        if (mul_done) begin
          if (round_r == ROUND_COORD) begin
            h_nxt     = fin;
            state_nxt = S_CHECK;
          end else begin
            x_nxt     = fin ^ word;
            round_nxt = round_up;
            state_nxt = S_ADD;
          end
        end
      end
      S_CHECK: begin
        if (req_r.func == chrd_pkg::FUNC_SIGN) begin
          state_nxt = S_DONE;
        end else if (h_r >= {{(HW - IW){1'b0}}, thr_r}) begin
          div_start = 1'b1;
          state_nxt = S_MOD;
        end else begin
          // Rejected: redo the whole chain with the next attempt number.
          attempt_nxt = attempt_r + HW'(1);
          x_nxt       = seed_ext;
          round_nxt   = ROUND_SEED;
          state_nxt   = S_ADD;
        end
      end
      S_MOD: begin
        if (div_done) begin
          idx_nxt   = div_rem;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        res_nxt.raw_value     = h_r;
        res_nxt.sign_positive = (req_r.func == chrd_pkg::FUNC_SIGN) & h_r[0];
        res_nxt.index         = idx_r;
        res_nxt.rejections    = (|attempt_r[HW-1:RW]) ? {RW{1'b1}} : attempt_r[RW-1:0];
        res_nxt.bad_bound     = bad_r;
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      seed_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid) begin
        seed_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    x_r       <= x_nxt;
    h_r       <= h_nxt;
    attempt_r <= attempt_nxt;
    thr_r     <= thr_nxt;
    idx_r     <= idx_nxt;
    round_r   <= round_nxt;
    bad_r     <= bad_nxt;
    if (out_load) begin
      res_r <= res_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = res_r;
  assign cfg_ready = 1'b1;

endmodule

`default_nettype wire
